// ===== rtl/histogram_median_filter_2d_unit_assert.svh =====
// Assertion macros shared by the median filter block.
`ifndef HISTOGRAM_MEDIAN_FILTER_2D_UNIT_ASSERT_SVH
`define HISTOGRAM_MEDIAN_FILTER_2D_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define HMF_ASSERT_IMP(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("implication check failed");
`define HMF_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("next-cycle check failed");
`else
`define HMF_ASSERT_IMP(label, clk, rst, a, b)
`define HMF_ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

// ===== rtl/hmf2d_pkg.sv =====
// Shared types and constants of the median filter block.
package hmf2d_pkg;
  localparam int WIDTH_BITS   = 11;
  localparam int HEIGHT_BITS  = 13;
  localparam int RADIUS_BITS  = 4;
  localparam int SLOT_BITS    = 5;
  localparam int SIDE_BITS    = 5;
  localparam int COUNT_BITS   = 10;
  localparam int ADDR_FULL    = SLOT_BITS + WIDTH_BITS;
  localparam int HEIGHT_LIMIT = 4096;
  localparam int RADIUS_LIMIT = 15;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_RADIUS = 2'd2;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_DRAIN = 1'b1;

  typedef struct packed {
    logic [WIDTH_BITS-1:0]  w;
    logic [HEIGHT_BITS-1:0] h;
    logic [RADIUS_BITS-1:0] r;
  } geom_t;

  typedef struct packed {
    logic [WIDTH_BITS-1:0]  ox;
    logic [HEIGHT_BITS-1:0] oy;
    logic [SLOT_BITS-1:0]   slot;
    logic                   frame_end;
  } job_t;

  typedef struct packed {
    logic                   busy;
    logic [HEIGHT_BITS-1:0] oy;
  } flight_t;
endpackage

// ===== rtl/hmf2d_ram.sv =====
// Generic simple dual-port RAM with registered read.
module hmf2d_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/hmf2d_queue.sv =====
// Two-entry job queue between the front and back parts.
module hmf2d_queue
  import hmf2d_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output job_t head,
  output logic empty,
  output logic full
);
  job_t       entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign empty = (count == 2'd0);
  assign full  = (count == 2'd2);
  assign head  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_job;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end
endmodule

// ===== rtl/hmf2d_front.sv =====
// Front part: registers, line store writes and output job scheduling.
module hmf2d_front
  import hmf2d_pkg::*;
#(
  parameter int SAMPLE_BITS = 8,
  parameter int MAX_WIDTH   = 1024,
  parameter int MAX_RADIUS  = 15
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [3:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  input  logic                   item_valid,
  output logic                   item_ready,
  input  logic                   kind,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  logic                   frame_start,
  output logic                   wr_en,
  output logic [ADDR_FULL-1:0]   wr_addr,
  output logic [SAMPLE_BITS-1:0] wr_data,
  output logic                   push,
  output job_t                   push_job,
  input  logic                   q_full,
  input  flight_t                flight,
  output geom_t                  geom
);
  localparam int W_MAX = (MAX_WIDTH > 2047) ? 2047 : MAX_WIDTH;
  localparam int R_MAX = (MAX_RADIUS > RADIUS_LIMIT) ? RADIUS_LIMIT : MAX_RADIUS;
  localparam int W_RST = (W_MAX < 1024) ? W_MAX : 1024;
  localparam logic [WIDTH_BITS-1:0]  W_MAX_L = WIDTH_BITS'(W_MAX);
  localparam logic [WIDTH_BITS-1:0]  W_RST_L = WIDTH_BITS'(W_RST);
  localparam logic [RADIUS_BITS-1:0] R_MAX_L = RADIUS_BITS'(R_MAX);
  localparam logic [HEIGHT_BITS-1:0] H_MAX_L = HEIGHT_BITS'(HEIGHT_LIMIT);

  geom_t                  cfg;
  geom_t                  act;
  logic [WIDTH_BITS-1:0]  in_col;
  logic [HEIGHT_BITS-1:0] in_row;
  logic [SLOT_BITS-1:0]   in_slot;
  logic [WIDTH_BITS-1:0]  out_col;
  logic [HEIGHT_BITS-1:0] out_row;
  logic [SLOT_BITS-1:0]   out_slot;

  logic                   accept;
  logic                   start;
  logic                   hazard_ok;
  logic                   cfg_wr;
  geom_t                  g;
  logic [WIDTH_BITS-1:0]  ic;
  logic [HEIGHT_BITS-1:0] ir;
  logic [SLOT_BITS-1:0]   is;
  logic [WIDTH_BITS-1:0]  oc;
  logic [HEIGHT_BITS-1:0] orow;
  logic [SLOT_BITS-1:0]   os;
  logic [WIDTH_BITS-1:0]  in_col_next;
  logic [HEIGHT_BITS-1:0] in_row_next;
  logic [SLOT_BITS-1:0]   in_slot_next;
  logic [WIDTH_BITS-1:0]  out_col_next;
  logic [HEIGHT_BITS-1:0] out_row_next;
  logic [SLOT_BITS-1:0]   out_slot_next;
  logic [WIDTH_BITS:0]    rx_sum;
  logic [HEIGHT_BITS:0]   ry_sum;
  logic [WIDTH_BITS-1:0]  rx;
  logic [HEIGHT_BITS-1:0] ry;
  logic [HEIGHT_BITS:0]   row_limit;
  logic [SLOT_BITS-1:0]   last_slot;
  logic [WIDTH_BITS-1:0]  v_w;
  logic [HEIGHT_BITS-1:0] v_h;
  logic [RADIUS_BITS-1:0] v_r;

  assign geom   = act;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    v_w = pwdata[WIDTH_BITS-1:0];
    if (v_w == '0) begin
      v_w = WIDTH_BITS'(1);
    end else if (v_w > W_MAX_L) begin
      v_w = W_MAX_L;
    end
    v_h = pwdata[HEIGHT_BITS-1:0];
    if (v_h == '0) begin
      v_h = HEIGHT_BITS'(1);
    end else if (v_h > H_MAX_L) begin
      v_h = H_MAX_L;
    end
    v_r = pwdata[RADIUS_BITS-1:0];
    if (v_r == '0) begin
      v_r = RADIUS_BITS'(1);
    end else if (v_r > R_MAX_L) begin
      v_r = R_MAX_L;
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_WIDTH:  prdata = 32'(cfg.w);
      REG_HEIGHT: prdata = 32'(cfg.h);
      REG_RADIUS: prdata = 32'(cfg.r);
      default:    prdata = 32'd0;
    endcase
  end

  always_comb begin
    row_limit = {1'b0, flight.oy} + (HEIGHT_BITS + 1)'(act.r) + (HEIGHT_BITS + 1)'(2);
    if (kind == KIND_DRAIN) begin
      hazard_ok = 1'b1;
    end else if (frame_start) begin
      hazard_ok = !flight.busy;
    end else begin
      hazard_ok = !flight.busy || (in_row >= act.h) || ({1'b0, in_row} < row_limit);
    end
    item_ready = !q_full && hazard_ok;
    accept     = item_valid && item_ready;
    start      = accept && (kind == KIND_PIXEL) && frame_start;

    g    = start ? cfg : act;
    ic   = start ? '0 : in_col;
    ir   = start ? '0 : in_row;
    is   = start ? '0 : in_slot;
    oc   = start ? '0 : out_col;
    orow = start ? '0 : out_row;
    os   = start ? '0 : out_slot;
    last_slot = {g.r, 1'b1};

    wr_en   = accept && (kind == KIND_PIXEL) && (ir < g.h);
    wr_addr = {is, ic};
    wr_data = sample;

    in_col_next  = ic;
    in_row_next  = ir;
    in_slot_next = is;
    if (wr_en) begin
      if ({1'b0, ic} + (WIDTH_BITS + 1)'(1) == {1'b0, g.w}) begin
        in_col_next  = '0;
        in_row_next  = ir + HEIGHT_BITS'(1);
        in_slot_next = (is == last_slot) ? '0 : is + SLOT_BITS'(1);
      end else begin
        in_col_next = ic + WIDTH_BITS'(1);
      end
    end

    rx_sum = {1'b0, oc} + (WIDTH_BITS + 1)'(g.r);
    rx     = (rx_sum < {1'b0, g.w}) ? rx_sum[WIDTH_BITS-1:0] : g.w - WIDTH_BITS'(1);
    ry_sum = {1'b0, orow} + (HEIGHT_BITS + 1)'(g.r);
    ry     = (ry_sum < {1'b0, g.h}) ? ry_sum[HEIGHT_BITS-1:0] : g.h - HEIGHT_BITS'(1);

    push = accept && (orow < g.h) &&
           ((in_row_next > ry) || ((in_row_next == ry) && (in_col_next > rx)));
    push_job.ox        = oc;
    push_job.oy        = orow;
    push_job.slot      = os;
    push_job.frame_end = (oc == g.w - WIDTH_BITS'(1)) && (orow == g.h - HEIGHT_BITS'(1));

    out_col_next  = oc;
    out_row_next  = orow;
    out_slot_next = os;
    if (push) begin
      if ({1'b0, oc} + (WIDTH_BITS + 1)'(1) == {1'b0, g.w}) begin
        out_col_next  = '0;
        out_row_next  = orow + HEIGHT_BITS'(1);
        out_slot_next = (os == last_slot) ? '0 : os + SLOT_BITS'(1);
      end else begin
        out_col_next = oc + WIDTH_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.w    <= W_RST_L;
      cfg.h    <= HEIGHT_BITS'(1024);
      cfg.r    <= RADIUS_BITS'(1);
      act.w    <= W_RST_L;
      act.h    <= HEIGHT_BITS'(1024);
      act.r    <= RADIUS_BITS'(1);
      in_col   <= '0;
      in_row   <= '0;
      in_slot  <= '0;
      out_col  <= '0;
      out_row  <= '0;
      out_slot <= '0;
    end else begin
      if (cfg_wr) begin
        unique case (paddr[3:2])
          REG_WIDTH:  cfg.w <= v_w;
          REG_HEIGHT: cfg.h <= v_h;
          REG_RADIUS: cfg.r <= v_r;
          default: begin
          end
        endcase
      end
      if (accept) begin
        act      <= g;
        in_col   <= in_col_next;
        in_row   <= in_row_next;
        in_slot  <= in_slot_next;
        out_col  <= out_col_next;
        out_row  <= out_row_next;
        out_slot <= out_slot_next;
      end
    end
  end
endmodule

// ===== rtl/hmf2d_back.sv =====
// Back part: window median by a bitwise search over counting passes.
module hmf2d_back
  import hmf2d_pkg::*;
#(
  parameter int SAMPLE_BITS = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  geom_t                  geom,
  input  job_t                   head,
  input  logic                   q_empty,
  output logic                   pop,
  output logic                   busy,
  output logic [HEIGHT_BITS-1:0] busy_oy,
  output logic [ADDR_FULL-1:0]   rd_addr,
  input  logic [SAMPLE_BITS-1:0] rd_data,
  output logic                   result_valid,
  input  logic                   result_ready,
  output logic [SAMPLE_BITS-1:0] median,
  output logic                   frame_end
);
  localparam int BIT_BITS = (SAMPLE_BITS > 1) ? $clog2(SAMPLE_BITS) : 1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SETUP, ST_SCAN, ST_FLUSH, ST_DECIDE, ST_OUTPUT
  } state_t;

  state_t                 state;
  job_t                   job;
  logic [WIDTH_BITS-1:0]  x0;
  logic [WIDTH_BITS-1:0]  x1;
  logic [HEIGHT_BITS-1:0] y0;
  logic [HEIGHT_BITS-1:0] y1;
  logic [SLOT_BITS-1:0]   slot0;
  logic [WIDTH_BITS-1:0]  x;
  logic [HEIGHT_BITS-1:0] y;
  logic [SLOT_BITS-1:0]   yslot;
  logic [COUNT_BITS-1:0]  bound;
  logic [COUNT_BITS-1:0]  cnt;
  logic [SAMPLE_BITS-1:0] prefix;
  logic [BIT_BITS-1:0]    bitn;
  logic                   rd_valid;

  logic [WIDTH_BITS:0]    xs;
  logic [HEIGHT_BITS:0]   ys;
  logic [WIDTH_BITS-1:0]  x0c;
  logic [WIDTH_BITS-1:0]  x1c;
  logic [HEIGHT_BITS-1:0] y0c;
  logic [HEIGHT_BITS-1:0] y1c;
  logic [SIDE_BITS-1:0]   nx;
  logic [SIDE_BITS-1:0]   ny;
  logic [COUNT_BITS-1:0]  area;
  logic [SLOT_BITS-1:0]   slot0c;
  logic [SAMPLE_BITS-1:0] test;
  logic [SAMPLE_BITS-1:0] prefix_next;
  logic [SLOT_BITS-1:0]   last_slot;

  assign pop     = (state == ST_IDLE) && !q_empty;
  assign busy    = (state != ST_IDLE);
  assign busy_oy = job.oy;
  assign rd_addr = {yslot, x};

  always_comb begin
    last_slot = {geom.r, 1'b1};
    xs  = {1'b0, job.ox} + (WIDTH_BITS + 1)'(geom.r);
    x1c = (xs < {1'b0, geom.w}) ? xs[WIDTH_BITS-1:0] : geom.w - WIDTH_BITS'(1);
    x0c = (job.ox >= WIDTH_BITS'(geom.r)) ? job.ox - WIDTH_BITS'(geom.r) : '0;
    ys  = {1'b0, job.oy} + (HEIGHT_BITS + 1)'(geom.r);
    y1c = (ys < {1'b0, geom.h}) ? ys[HEIGHT_BITS-1:0] : geom.h - HEIGHT_BITS'(1);
    y0c = (job.oy >= HEIGHT_BITS'(geom.r)) ? job.oy - HEIGHT_BITS'(geom.r) : '0;
    nx   = SIDE_BITS'(x1c - x0c + WIDTH_BITS'(1));
    ny   = SIDE_BITS'(y1c - y0c + HEIGHT_BITS'(1));
    area = COUNT_BITS'(nx) * COUNT_BITS'(ny);
    if (job.oy < HEIGHT_BITS'(geom.r)) begin
      slot0c = '0;
    end else if (job.slot >= SLOT_BITS'(geom.r)) begin
      slot0c = job.slot - SLOT_BITS'(geom.r);
    end else begin
      slot0c = SLOT_BITS'({1'b0, job.slot} + (SLOT_BITS + 1)'(geom.r) + (SLOT_BITS + 1)'(2));
    end
    for (int i = 0; i < SAMPLE_BITS; i++) begin
      test[i] = prefix[i] | (i < int'(bitn));
    end
    prefix_next = prefix;
    if (!(cnt > bound)) begin
      prefix_next[bitn] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      rd_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      rd_valid <= (state == ST_SCAN);
      if (rd_valid && (rd_data <= test)) begin
        cnt <= cnt + COUNT_BITS'(1);
      end
      if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (!q_empty) begin
            job   <= head;
            state <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          x0     <= x0c;
          x1     <= x1c;
          y0     <= y0c;
          y1     <= y1c;
          slot0  <= slot0c;
          x      <= x0c;
          y      <= y0c;
          yslot  <= slot0c;
          bound  <= area >> 1;
          cnt    <= '0;
          prefix <= '0;
          bitn   <= BIT_BITS'(SAMPLE_BITS - 1);
          state  <= ST_SCAN;
        end
        ST_SCAN: begin
          if (x == x1) begin
            x <= x0;
            if (y == y1) begin
              state <= ST_FLUSH;
            end else begin
              y     <= y + HEIGHT_BITS'(1);
              yslot <= (yslot == last_slot) ? '0 : yslot + SLOT_BITS'(1);
            end
          end else begin
            x <= x + WIDTH_BITS'(1);
          end
        end
        ST_FLUSH: begin
          state <= ST_DECIDE;
        end
        ST_DECIDE: begin
          prefix <= prefix_next;
          if (bitn == '0) begin
            state <= ST_OUTPUT;
          end else begin
            bitn  <= bitn - BIT_BITS'(1);
            x     <= x0;
            y     <= y0;
            yslot <= slot0;
            cnt   <= '0;
            state <= ST_SCAN;
          end
        end
        ST_OUTPUT: begin
          if (!result_valid || result_ready) begin
            result_valid <= 1'b1;
            median       <= prefix;
            frame_end    <= job.frame_end;
            state        <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule

// ===== rtl/histogram_median_filter_2d_unit.sv =====
// Top level of the 2D median filter with a decoupled front and back part.
//
//   channel  direction  handshake                  payload
//   item     in         item_valid / item_ready    kind, sample, frame_start
//   result   out        result_valid / result_ready median, frame_end
//   config   in         APB psel/penable/pready    paddr, pwdata, prdata
//
// A request is taken by the front when the job queue has room and the row hazard check lets it pass.
// Each median takes SAMPLE_BITS counting passes over the clipped window in the
// line store read port.
// Reset is synchronous; the line store is not cleared and needs no sweep.
// The front stalls a pixel that would overwrite a row still needed by a job.
module histogram_median_filter_2d_unit
  import hmf2d_pkg::*;
#(
  parameter int SAMPLE_BITS = 8,
  parameter int MAX_WIDTH   = 1024,
  parameter int MAX_RADIUS  = 15
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [3:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  input  logic                   item_valid,
  output logic                   item_ready,
  input  logic                   kind,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  logic                   frame_start,
  output logic                   result_valid,
  input  logic                   result_ready,
  output logic [SAMPLE_BITS-1:0] median,
  output logic                   frame_end
);
`include "histogram_median_filter_2d_unit_assert.svh"

  localparam int R_EFF      = (MAX_RADIUS > RADIUS_LIMIT) ? RADIUS_LIMIT : MAX_RADIUS;
  localparam int STORE_ROWS = 2 * R_EFF + 2;
  localparam int DEPTH      = STORE_ROWS * (2 ** WIDTH_BITS);
  localparam int ADDR_BITS  = $clog2(DEPTH);

  logic                   wr_en;
  logic [ADDR_FULL-1:0]   wr_addr;
  logic [SAMPLE_BITS-1:0] wr_data;
  logic [ADDR_FULL-1:0]   rd_addr;
  logic [SAMPLE_BITS-1:0] rd_data;
  logic                   push;
  job_t                   push_job;
  logic                   pop;
  job_t                   head;
  logic                   q_empty;
  logic                   q_full;
  logic                   back_busy;
  logic [HEIGHT_BITS-1:0] back_oy;
  flight_t                flight;
  geom_t                  geom;

  assign pready      = 1'b1;
  assign flight.busy = back_busy || !q_empty;
  assign flight.oy   = back_busy ? back_oy : head.oy;

  hmf2d_front #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .kind       (kind),
    .sample     (sample),
    .frame_start(frame_start),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .push       (push),
    .push_job   (push_job),
    .q_full     (q_full),
    .flight     (flight),
    .geom       (geom)
  );

  hmf2d_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_job(push_job),
    .pop     (pop),
    .head    (head),
    .empty   (q_empty),
    .full    (q_full)
  );

  hmf2d_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_addr[ADDR_BITS-1:0]),
    .wdata(wr_data),
    .raddr(rd_addr[ADDR_BITS-1:0]),
    .rdata(rd_data)
  );

  hmf2d_back #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .geom        (geom),
    .head        (head),
    .q_empty     (q_empty),
    .pop         (pop),
    .busy        (back_busy),
    .busy_oy     (back_oy),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .median      (median),
    .frame_end   (frame_end)
  );

  `HMF_ASSERT_IMP(a_push_room, clk, rst, push, !q_full)
  `HMF_ASSERT_IMP(a_start_idle, clk, rst, item_valid && item_ready && (kind == KIND_PIXEL) && frame_start, !flight.busy)
  `HMF_ASSERT_NEXT(a_job_tracked, clk, rst, push && !flight.busy, flight.busy)
endmodule

// ===== sim/tb_histogram_median_filter_2d_unit.sv =====
// Self-checking testbench for the 2D histogram median filter unit.
`timescale 1ns / 100ps

module tb_histogram_median_filter_2d_unit;
  import hmf2d_pkg::*;

  typedef struct packed {
    logic [7:0] median;
    logic       frame_end;
  } median_result_t;

  class median_scoreboard;
    int unsigned reg_w = 1024;
    int unsigned reg_h = 1024;
    int unsigned reg_r = 1;
    int unsigned act_w = 1024;
    int unsigned act_h = 1024;
    int unsigned act_r = 1;
    int unsigned in_pos;
    int unsigned out_pos;
    logic [7:0] line_mem [32*1024];
    median_result_t medians_due [$];

    function int unsigned clamp(int unsigned v, int unsigned lo, int unsigned hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function void write_reg(logic [1:0] idx, int unsigned v);
      case (idx)
        REG_WIDTH: reg_w = clamp(v & 'h7FF, 1, 1024);
        REG_HEIGHT: reg_h = clamp(v & 'h1FFF, 1, HEIGHT_LIMIT);
        REG_RADIUS: reg_r = clamp(v & 'hF, 1, RADIUS_LIMIT);
        default: ;
      endcase
    endfunction

    function int unsigned slot_addr(int unsigned col, int unsigned row);
      return (row % (2 * act_r + 2)) * 1024 + col;
    endfunction

    function logic [7:0] window_median(int unsigned ox, int unsigned oy);
      int unsigned x0, y0, x1, y1, bound, sum;
      int unsigned hist [256];
      x0 = ox >= act_r ? ox - act_r : 0;
      y0 = oy >= act_r ? oy - act_r : 0;
      x1 = (ox + act_r < act_w) ? ox + act_r : act_w - 1;
      y1 = (oy + act_r < act_h) ? oy + act_r : act_h - 1;
      bound = ((x1 - x0 + 1) * (y1 - y0 + 1)) / 2;
      foreach (hist[i]) hist[i] = 0;
      for (int unsigned y = y0; y <= y1; y++) begin
        for (int unsigned x = x0; x <= x1; x++) begin
          hist[line_mem[slot_addr(x, y)]]++;
        end
      end
      sum = 0;
      for (int v = 0; v < 255; v++) begin
        sum += hist[v];
        if (sum > bound) return v[7:0];
      end
      return 8'd255;
    endfunction

    function void take_item(logic k, logic [7:0] s, logic fs);
      int unsigned total, ox, oy, rx, ry;
      median_result_t res;
      if (k == KIND_PIXEL) begin
        if (fs) begin
          act_w = reg_w;
          act_h = reg_h;
          act_r = reg_r;
          in_pos = 0;
          out_pos = 0;
        end
        if (in_pos < act_w * act_h) begin
          line_mem[slot_addr(in_pos % act_w, in_pos / act_w)] = s;
          in_pos++;
        end
      end
      total = act_w * act_h;
      if (out_pos >= total) return;
      ox = out_pos % act_w;
      oy = out_pos / act_w;
      rx = (ox + act_r < act_w) ? ox + act_r : act_w - 1;
      ry = (oy + act_r < act_h) ? oy + act_r : act_h - 1;
      if (in_pos <= ry * act_w + rx) return;
      res.median = window_median(ox, oy);
      res.frame_end = (out_pos + 1 == total);
      medians_due.push_back(res);
      out_pos++;
    endfunction

    function int unsigned outputs_left();
      return act_w * act_h - out_pos;
    endfunction

    function bit check(logic [7:0] m, logic fe, output string msg);
      median_result_t want;
      if (medians_due.size() == 0) begin
        msg = $sformatf("unexpected result median=%0d frame_end=%0b", m, fe);
        return 0;
      end
      want = medians_due.pop_front();
      if (m !== want.median || fe !== want.frame_end) begin
        msg = $sformatf("median %0d/%0d frame_end %0b/%0b (got/want)",
                        m, want.median, fe, want.frame_end);
        return 0;
      end
      return 1;
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic psel = 0;
  logic penable = 0;
  logic pwrite = 0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic item_valid = 0;
  logic item_ready;
  logic kind = 0;
  logic [7:0] sample = '0;
  logic frame_start = 0;
  logic result_valid;
  logic result_ready = 0;
  logic [7:0] median;
  logic frame_end;

  median_scoreboard board = new();
  int errors = 0;
  int items_sent = 0;
  bit calm = 1;
  int stall_left = 0;

  histogram_median_filter_2d_unit uut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #30ms;
    $display("tb_histogram_median_filter_2d_unit: errors");
    $finish;
  end

  task automatic report(string msg);
    errors++;
    $display("%0t mismatch: %s", $time, msg);
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  initial begin
    string msg;
    forever begin
      @(posedge clk);
      if (!rst && result_valid && result_ready) begin
        if (!board.check(median, frame_end, msg)) report(msg);
      end
      if (stall_left > 0) begin
        stall_left--;
        result_ready <= 0;
      end else begin
        stall_left = pick_gap();
        result_ready <= (stall_left == 0);
      end
    end
  end

  task automatic apb_write(logic [1:0] idx, int unsigned v);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= {idx, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    board.write_reg(idx, v);
  endtask

  task automatic wait_drain();
    item_valid <= 0;
    while (board.medians_due.size() > 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic send(logic k, logic [7:0] s, logic fs);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      item_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1;
    kind <= k;
    sample <= s;
    frame_start <= fs;
    do @(posedge clk); while (!item_ready);
    board.take_item(k, s, fs);
    items_sent++;
  endtask

  task automatic configure(int unsigned w, int unsigned h, int unsigned r);
    wait_drain();
    apb_write(REG_WIDTH, w);
    apb_write(REG_HEIGHT, h);
    apb_write(REG_RADIUS, r);
  endtask

  function automatic logic [7:0] pattern_sample(int pat, int unsigned i);
    case (pat)
      0: return 8'($urandom_range(0, 255));
      1: return 8'($urandom_range(0, 3) * 85);
      2: return $urandom_range(0, 1) ? 8'd255 : 8'd0;
      default: return 8'(i * 7);
    endcase
  endfunction

  task automatic flush_frame();
    while (board.outputs_left() > 0) send(KIND_DRAIN, 8'($urandom), 1'($urandom));
  endtask

  task automatic random_frame();
    int unsigned w, h, r, npix, mode, pat;
    w = $urandom_range(1, 12);
    h = $urandom_range(1, 6);
    mode = $urandom_range(0, 9);
    r = mode < 7 ? $urandom_range(1, 2) : $urandom_range(3, 15);
    if (r > 5) begin
      w = $urandom_range(1, 6);
      h = $urandom_range(1, 4);
    end
    configure(w, h, r);
    calm = ($urandom_range(0, 5) == 0);
    pat = $urandom_range(0, 3);
    mode = $urandom_range(0, 9);
    npix = w * h;
    if (mode == 0) npix = $urandom_range(1, w * h);
    else if (mode == 1) npix = w * h + $urandom_range(1, 3);
    for (int unsigned i = 0; i < npix; i++) begin
      if ($urandom_range(0, 99) < 8) send(KIND_DRAIN, 8'($urandom), 1'($urandom));
      if (mode == 2 && i == npix / 2) wait_drain();
      send(KIND_PIXEL, pattern_sample(pat, i), i == 0);
    end
    if (mode != 0) flush_frame();
  endtask

  initial begin
    logic [7:0] corner [9] = '{8'd0, 8'd255, 8'd128, 8'd1, 8'd254,
                               8'd127, 8'd0, 8'd255, 8'd200};
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    send(KIND_DRAIN, 8'd0, 1'b1);
    configure(3, 3, 1);
    foreach (corner[i]) send(KIND_PIXEL, corner[i], i == 0);
    send(KIND_PIXEL, 8'd99, 1'b0);
    flush_frame();
    configure(1, 1, 1);
    send(KIND_PIXEL, 8'd77, 1'b1);
    send(KIND_DRAIN, 8'd255, 1'b0);

    calm = 0;
    configure(0, 8191, 0);
    for (int i = 0; i < 40; i++) send(KIND_PIXEL, 8'($urandom), i == 0);
    configure(2047, 1, 15);
    for (int i = 0; i < 1024; i++) send(KIND_PIXEL, 8'($urandom), i == 0);
    flush_frame();

    while (items_sent < 1700) random_frame();
    item_valid <= 0;
    calm = 0;

    while (board.medians_due.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("tb_histogram_median_filter_2d_unit: clean");
    end else begin
      $display("tb_histogram_median_filter_2d_unit: errors");
    end
    $finish;
  end
endmodule
